[rtl/nhhm_pkg.sv]
package nhhm_pkg;

  localparam int SLOTS         = 8;
  localparam int ID_W          = 8;
  localparam int STAMP_W       = 32;
  localparam int COUNT_W       = 4;
  localparam int CMD_W         = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int MAX_NODES_DEF = 8;
  localparam int NODE_ID_MAX   = 63;

  typedef enum logic [CMD_W-1:0] {
    CMD_START     = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_EVALUATE  = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_BAD_ARG   = 2'd2,
    ST_UNTRACKED = 2'd3
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRACKED_NODES = 2'd0,
    REG_TRACKED_COUNT = 2'd1,
    REG_OWN_NODE      = 2'd2,
    REG_TIMEOUT_MS    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    node_id;
    logic [STAMP_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic               alive;
    logic [STAMP_W-1:0] last_seen_ms;
    logic [SLOTS-1:0]   alive_mask;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/nhhm_ctrl.sv]
module nhhm_ctrl import nhhm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dp_status_t       st,
  output ctrl_cmd_t        ctl,
  output logic [IDX_W-1:0] idx
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_NODES - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   finish_ok;

  assign finish_ok  = (state == S_FINISH) && !st.out_busy;
  assign in_stall   = !((state == S_IDLE) || finish_ok);
  assign accept     = in_valid && !in_stall;
  assign ctl.load   = accept;
  assign ctl.step   = (state == S_SWEEP);
  assign ctl.finish = finish_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (idx == LAST) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (finish_ok) state_next = accept ? S_SWEEP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if (ctl.step && idx != LAST) begin
        idx <= idx + 1'b1;
      end
    end
  end

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && idx == LAST) |=> (state == S_FINISH))
    else $error("sweep did not end in finish");

  a_load_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == S_SWEEP && idx == '0))
    else $error("accepted item did not start a sweep at entry zero");

endmodule

[rtl/nhhm_dp.sv]
module nhhm_dp import nhhm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  item_t                  in_data,
  input  ctrl_cmd_t              ctl,
  input  logic [IDX_W-1:0]       idx,
  output dp_status_t             st,
  output logic                   out_valid,
  input  logic                   out_stall,
  output result_t                out_data,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CFG_DATA_W-1:0] cfg_nodes;
  logic [COUNT_W-1:0]    cfg_count;
  logic [ID_W-1:0]       cfg_own;
  logic [STAMP_W-1:0]    cfg_timeout;

  logic [ID_W-1:0]    lat_ids [MAX_NODES];
  logic [COUNT_W-1:0] lat_count;
  logic [ID_W-1:0]    lat_own;
  logic [STAMP_W-1:0] lat_timeout;
  logic               started;

  logic [STAMP_W-1:0]   last_seen [MAX_NODES];
  logic [MAX_NODES-1:0] alive_flags;

  cmd_e               req_cmd;
  logic [ID_W-1:0]    req_id;
  logic [STAMP_W-1:0] req_now;
  logic               active;
  status_e            res_status;
  logic               found;
  logic               res_alive;
  logic [STAMP_W-1:0] res_seen;

  cmd_e               in_cmd;
  logic               start_ok;
  logic               id_bad;
  status_e            load_status;
  logic               load_active;
  logic               in_range;
  logic               id_hit;
  logic               own_hit;
  logic [STAMP_W-1:0] age;
  logic               untracked;
  logic               query_hit;
  result_t            result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nodes   <= '0;
      cfg_count   <= '0;
      cfg_own     <= '0;
      cfg_timeout <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_TRACKED_NODES: cfg_nodes   <= cfg_data;
        REG_TRACKED_COUNT: cfg_count   <= cfg_data[COUNT_W-1:0];
        REG_OWN_NODE:      cfg_own     <= cfg_data[ID_W-1:0];
        REG_TIMEOUT_MS:    cfg_timeout <= cfg_data[STAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    start_ok = (cfg_count != '0) && (cfg_count <= COUNT_W'(MAX_NODES)) &&
               (cfg_timeout != '0);
    for (int i = 0; i < MAX_NODES; i++) begin
      if ((COUNT_W'(i) < cfg_count) &&
          (cfg_nodes[ID_W*i +: ID_W] > ID_W'(NODE_ID_MAX))) begin
        start_ok = 1'b0;
      end
    end
  end

  assign in_cmd = cmd_e'(in_data.cmd);
  assign id_bad = in_data.node_id > ID_W'(NODE_ID_MAX);

  always_comb begin
    load_status = ST_OK;
    load_active = 1'b0;
    if (in_cmd == CMD_START) begin
      load_status = start_ok ? ST_OK : ST_BAD_ARG;
      load_active = start_ok;
    end else if (!started) begin
      load_status = ST_IGNORED;
    end else begin
      unique case (in_cmd)
        CMD_HEARTBEAT: begin
          if (id_bad) begin
            load_status = ST_BAD_ARG;
          end else if (in_data.node_id == lat_own) begin
            load_status = ST_IGNORED;
          end else begin
            load_active = 1'b1;
          end
        end
        CMD_EVALUATE: begin
          load_active = 1'b1;
        end
        CMD_QUERY: begin
          if (id_bad) begin
            load_status = ST_BAD_ARG;
          end else begin
            load_active = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_count   <= '0;
      lat_own     <= '0;
      lat_timeout <= '0;
      started     <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) lat_ids[i] <= '0;
    end else if (ctl.load && in_cmd == CMD_START && start_ok) begin
      lat_count   <= cfg_count;
      lat_own     <= cfg_own;
      lat_timeout <= cfg_timeout;
      started     <= 1'b1;
      for (int i = 0; i < MAX_NODES; i++) lat_ids[i] <= cfg_nodes[ID_W*i +: ID_W];
    end
  end

  assign in_range = COUNT_W'(idx) < lat_count;
  assign id_hit   = lat_ids[idx] == req_id;
  assign own_hit  = lat_ids[idx] == lat_own;
  assign age      = req_now - last_seen[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      alive_flags <= '0;
      for (int i = 0; i < MAX_NODES; i++) last_seen[i] <= '0;
    end else if (ctl.step && active) begin
      unique case (req_cmd)
        CMD_START: begin
          last_seen[idx]   <= (in_range && own_hit) ? req_now : '0;
          alive_flags[idx] <= in_range && own_hit;
        end
        CMD_HEARTBEAT: begin
          if (in_range && id_hit && !found) begin
            last_seen[idx]   <= req_now;
            alive_flags[idx] <= 1'b1;
          end
        end
        CMD_EVALUATE: begin
          if (in_range) begin
            if (own_hit) begin
              last_seen[idx]   <= req_now;
              alive_flags[idx] <= 1'b1;
            end else begin
              alive_flags[idx] <= (last_seen[idx] != '0) && (age < lat_timeout);
            end
          end
        end
        CMD_QUERY: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      found  <= 1'b0;
    end else if (ctl.load) begin
      active <= load_active;
      found  <= 1'b0;
    end else if (ctl.step && active && in_range && id_hit && !found) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd    <= in_cmd;
      req_id     <= in_data.node_id;
      req_now    <= in_data.now_ms;
      res_status <= load_status;
    end else if (ctl.step && active && in_range && id_hit && !found) begin
      res_alive <= alive_flags[idx];
      res_seen  <= last_seen[idx];
    end
  end

  assign untracked = active && !found &&
                     (req_cmd == CMD_HEARTBEAT || req_cmd == CMD_QUERY);
  assign query_hit = active && found && (req_cmd == CMD_QUERY);

  always_comb begin
    result_next.status       = untracked ? ST_UNTRACKED : res_status;
    result_next.alive        = query_hit && res_alive;
    result_next.last_seen_ms = query_hit ? res_seen : '0;
    result_next.alive_mask   = SLOTS'(alive_flags);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) out_data <= result_next;
  end

  assign st.out_busy = out_valid && out_stall;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !(out_valid && out_stall))
    else $error("result written over an item not yet taken");

  a_dead_before_start: assert property (@(posedge clk) disable iff (rst)
    !started |-> (alive_flags == '0))
    else $error("alive flag set before a successful start");

  a_fail_no_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |->
      (!out_data.alive && out_data.last_seen_ms == '0))
    else $error("entry fields reported on a failed command");

endmodule

[rtl/node_heartbeat_health_monitor.sv]
// Heartbeat liveness monitor for up to MAX_NODES tracked nodes. Each item is a
// start, heartbeat, evaluate or query command and yields exactly one result with
// a status, the queried entry and the alive mask. An item's result is set by the
// table sweep that follows its acceptance and visits one entry per cycle; the
// next item is taken in the cycle the result is loaded into the output register,
// unless that register still holds an item that has not been taken.
// Configuration registers take effect at the next successful start; the user must
// write them only while no item is in flight, as the block does not enforce this.
module node_heartbeat_health_monitor import nhhm_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  item_t                  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output result_t                out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  ctrl_cmd_t        ctl;
  dp_status_t       st;
  logic [IDX_W-1:0] idx;

  assign cfg_ready = 1'b1;

  nhhm_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl),
    .idx      (idx)
  );

  nhhm_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .ctl       (ctl),
    .idx       (idx),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
